@@ rtl/psa_pkg.sv @@
package psa_pkg;

  localparam logic [31:0] NONE_HANDLE = 32'hFFFF_FFFF;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [7:0] priority_req;
    logic [31:0]       handle;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] granted_handle;
    logic [2:0]  light_number;
    logic        was_stolen;
    logic        disable_light;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       owner;
    logic signed [7:0] prio;
  } entry_t;

  localparam rsp_t RSP_IDLE = '{
    ok: 1'b0,
    granted_handle: NONE_HANDLE,
    light_number: 3'd0,
    was_stolen: 1'b0,
    disable_light: 1'b0
  };

  localparam entry_t ENTRY_FREE = '{owner: NONE_HANDLE, prio: 8'sd0};

endpackage

@@ rtl/priority_slot_allocator_top.sv @@
// Channel | Ports                  | Beat taken when
// --------+------------------------+------------------------------
// request | start, busy, req       | start high and busy low
// result  | done, result           | every cycle that done is high
//
// The slots are scanned through the single read port of the slot memory,
// one per cycle, with registered read data, and the scan stops at the first
// slot that settles the answer.
// An unused action code gives its result in the cycle after it is taken.
// Reset is synchronous and leaves every slot free and the handle counter at 0.
// The result is shown for one cycle only; the receiver cannot stall it.
module priority_slot_allocator_top #(
  parameter int SLOTS = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  psa_pkg::req_t req,
  output logic          done,
  output psa_pkg::rsp_t result
);
  import psa_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t           state;
  req_t             cur;
  logic [CNT_W-1:0] scan_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             steal_found;
  logic [IDX_W-1:0] steal_idx;
  logic [31:0]      next_handle;

  logic             rd_en;
  entry_t           rd_entry;
  logic             rd_vld;
  logic             wr_en;
  logic             wr_clr;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;

  logic             last;
  logic             is_free;
  logic             can_steal;
  logic             is_match;
  logic             decide;
  rsp_t             rsp_next;
  logic [31:0]      grant_handle;
  logic [IDX_W-1:0] pick_idx;
  logic [31:0]      light_wide;

  assign busy  = (state != ST_IDLE);
  assign rd_en = (state == ST_SCAN) && (scan_idx < CNT_W'(SLOTS));

  assign last      = (rd_idx == IDX_W'(SLOTS - 1));
  assign is_free   = (rd_entry.owner == NONE_HANDLE);
  assign can_steal = !steal_found && (cur.priority_req > rd_entry.prio);
  assign is_match  = (cur.handle != NONE_HANDLE) && (rd_entry.owner == cur.handle);
  assign grant_handle = (next_handle == NONE_HANDLE) ? 32'd0 : next_handle;
  assign pick_idx     = (cur.action == ACT_ALLOC && !is_free && steal_found) ?
                        steal_idx : rd_idx;
  assign light_wide   = 32'(pick_idx) + 32'd1;

  always_comb begin
    decide   = 1'b0;
    rsp_next = RSP_IDLE;
    wr_en    = 1'b0;
    wr_clr   = 1'b0;
    wr_entry = '{owner: grant_handle, prio: cur.priority_req};
    if (state == ST_SCAN && rd_vld) begin
      case (cur.action)
        ACT_ALLOC: begin
          if (is_free) begin
            decide = 1'b1;
            wr_en  = 1'b1;
          end else if (last) begin
            decide = 1'b1;
            if (steal_found || can_steal) begin
              wr_en               = 1'b1;
              rsp_next.was_stolen = 1'b1;
            end
          end
          if (wr_en) begin
            rsp_next.ok             = 1'b1;
            rsp_next.granted_handle = grant_handle;
            rsp_next.light_number   = light_wide[2:0];
          end
        end
        ACT_RELEASE: begin
          if (is_match || last) begin
            decide = 1'b1;
          end
          if (is_match) begin
            wr_clr                 = 1'b1;
            rsp_next.ok            = 1'b1;
            rsp_next.disable_light = 1'b1;
            rsp_next.light_number  = light_wide[2:0];
          end
        end
        ACT_LOOKUP: begin
          if (is_match || last) begin
            decide = 1'b1;
          end
          if (is_match) begin
            rsp_next.ok           = 1'b1;
            rsp_next.light_number = light_wide[2:0];
          end
        end
        default: begin
          decide = 1'b1;
        end
      endcase
    end
  end

  assign wr_addr = pick_idx;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur <= req;
    end
    if (rd_en) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (state == ST_SCAN && rd_vld && can_steal && !is_free) begin
      steal_idx <= rd_idx;
    end
    if (decide || (start && !busy && req.action == ACT_NONE)) begin
      result <= decide ? rsp_next : RSP_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_idx    <= '0;
      steal_found <= 1'b0;
      next_handle <= 32'd0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (req.action == ACT_NONE) begin
              done <= 1'b1;
            end else begin
              state       <= ST_SCAN;
              scan_idx    <= '0;
              steal_found <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (rd_vld && can_steal && !is_free) begin
            steal_found <= 1'b1;
          end
          if (decide) begin
            state <= ST_IDLE;
            done  <= 1'b1;
            if (wr_en) begin
              next_handle <= grant_handle + 32'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  psa_slot_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_entry(rd_entry),
    .rd_vld  (rd_vld),
    .wr_en   (wr_en),
    .wr_clr  (wr_clr),
    .wr_addr (wr_addr),
    .wr_entry(wr_entry)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.action != ACT_NONE) |=> busy)
    else $error("Block not busy after taking a scanning request.");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result shown while a scan is still running.");

  a_handle_only_on_grant: assert property (@(posedge clk) disable iff (rst)
    (done && result.granted_handle != NONE_HANDLE) |-> (result.ok && !result.disable_light))
    else $error("Handle given out without a grant.");

  a_read_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == ST_SCAN))
    else $error("Slot read returned outside a scan.");

endmodule

@@ rtl/psa_slot_store.sv @@
module psa_slot_store #(
  parameter int SLOTS = 7
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output psa_pkg::entry_t                       rd_entry,
  output logic                                  rd_vld,
  input  logic                                  wr_en,
  input  logic                                  wr_clr,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  psa_pkg::entry_t                       wr_entry
);
  import psa_pkg::*;

  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] live;
  entry_t           mem_q;
  logic             live_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live   <= '0;
      live_q <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (rd_en) begin
        live_q <= live[rd_addr];
      end
      if (wr_en) begin
        live[wr_addr] <= 1'b1;
      end else if (wr_clr) begin
        live[wr_addr] <= 1'b0;
      end
    end
  end

  // A slot that was never granted, or was released, reads as free.
  assign rd_entry = live_q ? mem_q : ENTRY_FREE;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import psa_pkg::*;

  localparam int SLOTS = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t result;

  logic [31:0] owner_of [SLOTS];
  logic signed [7:0] prio_of [SLOTS];
  logic [31:0] handle_ctr;

  rsp_t pending_outcomes [$];
  int mismatch_count = 0;
  int idle_pct = 0;

  priority_slot_allocator_top #(.SLOTS(SLOTS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_slots();
    for (int i = 0; i < SLOTS; i++) begin
      owner_of[i] = NONE_HANDLE;
      prio_of[i] = 8'sd0;
    end
    handle_ctr = 32'd0;
  endfunction

  function automatic rsp_t predict_outcome(req_t r);
    rsp_t o;
    int pick;
    int steal;
    int hit;
    logic [31:0] grant;
    o = RSP_IDLE;
    pick = -1;
    steal = -1;
    hit = -1;
    case (r.action)
      ACT_ALLOC: begin
        for (int i = 0; i < SLOTS && pick < 0; i++) begin
          if (owner_of[i] == NONE_HANDLE) begin
            pick = i;
          end else if (steal < 0 && r.priority_req > prio_of[i]) begin
            steal = i;
          end
        end
        if (pick < 0 && steal >= 0) begin
          pick = steal;
          o.was_stolen = 1'b1;
        end
        if (pick >= 0) begin
          grant = (handle_ctr == NONE_HANDLE) ? 32'd0 : handle_ctr;
          handle_ctr = grant + 32'd1;
          owner_of[pick] = grant;
          prio_of[pick] = r.priority_req;
          o.ok = 1'b1;
          o.granted_handle = grant;
          o.light_number = 3'(pick + 1);
        end
      end
      ACT_RELEASE, ACT_LOOKUP: begin
        if (r.handle != NONE_HANDLE) begin
          for (int i = 0; i < SLOTS && hit < 0; i++) begin
            if (owner_of[i] == r.handle) begin
              hit = i;
            end
          end
        end
        if (hit >= 0) begin
          o.ok = 1'b1;
          o.light_number = 3'(hit + 1);
          if (r.action == ACT_RELEASE) begin
            owner_of[hit] = NONE_HANDLE;
            o.disable_light = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] action, logic signed [7:0] prio,
                                    logic [31:0] handle);
    req_t r;
    r.action = action;
    r.priority_req = prio;
    r.handle = handle;
    return r;
  endfunction

  function automatic logic [31:0] pick_handle();
    int live [$];
    int roll;
    for (int i = 0; i < SLOTS; i++) begin
      if (owner_of[i] != NONE_HANDLE) begin
        live.push_back(i);
      end
    end
    roll = $urandom_range(99);
    if (roll < 70 && live.size() > 0) begin
      return owner_of[live[$urandom_range(live.size() - 1)]];
    end else if (roll < 80) begin
      return NONE_HANDLE;
    end else if (roll < 90) begin
      return handle_ctr - 32'($urandom_range(1, 20));
    end
    return $urandom();
  endfunction

  function automatic req_t random_request();
    req_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      r.action = ACT_ALLOC;
    end else if (roll < 70) begin
      r.action = ACT_RELEASE;
    end else if (roll < 95) begin
      r.action = ACT_LOOKUP;
    end else begin
      r.action = ACT_NONE;
    end
    roll = $urandom_range(9);
    if (roll == 0) begin
      r.priority_req = 8'sh80;
    end else if (roll == 1) begin
      r.priority_req = 8'sh7F;
    end else begin
      r.priority_req = 8'($urandom());
    end
    r.handle = pick_handle();
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("tb: mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
    end
    mismatch_count++;
  endtask

  task automatic issue_request(req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(predict_outcome(r));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected beat", result.granted_handle, NONE_HANDLE);
      end else begin
        want = pending_outcomes.pop_front();
        if (result.ok !== want.ok) begin
          flag_mismatch("ok", result.ok, want.ok);
        end
        if (result.granted_handle !== want.granted_handle) begin
          flag_mismatch("granted_handle", result.granted_handle, want.granted_handle);
        end
        if (result.light_number !== want.light_number) begin
          flag_mismatch("light_number", result.light_number, want.light_number);
        end
        if (result.was_stolen !== want.was_stolen) begin
          flag_mismatch("was_stolen", result.was_stolen, want.was_stolen);
        end
        if (result.disable_light !== want.disable_light) begin
          flag_mismatch("disable_light", result.disable_light, want.disable_light);
        end
      end
    end
  end

  task automatic test_empty_pool();
    issue_request(make_req(ACT_LOOKUP, 8'sd0, 32'd0));
    issue_request(make_req(ACT_RELEASE, 8'sd0, NONE_HANDLE));
    issue_request(make_req(ACT_NONE, 8'sh7F, 32'h5A5A_A5A5));
  endtask

  task automatic test_fill_and_preempt();
    issue_request(make_req(ACT_ALLOC, 8'sh80, 32'd0));
    issue_request(make_req(ACT_ALLOC, 8'sh7F, NONE_HANDLE));
    issue_request(make_req(ACT_ALLOC, 8'sd0, 32'd0));
    issue_request(make_req(ACT_ALLOC, -8'sd1, 32'd0));
    issue_request(make_req(ACT_ALLOC, 8'sd1, 32'd0));
    issue_request(make_req(ACT_ALLOC, 8'sd5, 32'd0));
    issue_request(make_req(ACT_ALLOC, 8'sh80, 32'd0));
    // With every slot taken, an equal priority must not preempt anyone.
    issue_request(make_req(ACT_ALLOC, 8'sh80, 32'd0));
    issue_request(make_req(ACT_ALLOC, 8'sh7F, 32'd0));
    issue_request(make_req(ACT_ALLOC, 8'sh7F, 32'd0));
  endtask

  task automatic test_release_and_lookup();
    issue_request(make_req(ACT_LOOKUP, 8'sd0, owner_of[SLOTS - 1]));
    issue_request(make_req(ACT_LOOKUP, 8'sd0, NONE_HANDLE));
    issue_request(make_req(ACT_LOOKUP, 8'sd0, 32'd0));
    issue_request(make_req(ACT_RELEASE, 8'sd0, owner_of[3]));
    issue_request(make_req(ACT_RELEASE, 8'sd0, 32'd3));
    issue_request(make_req(ACT_ALLOC, 8'sh80, 32'hFFFF_FFFE));
    issue_request(make_req(ACT_LOOKUP, 8'sh7F, 32'h7FFF_FFFF));
    issue_request(make_req(ACT_RELEASE, 8'sh80, NONE_HANDLE));
  endtask

  task automatic test_random_traffic(int pct, int count);
    idle_pct = pct;
    repeat (count) begin
      issue_request(random_request());
    end
  endtask

  initial begin
    clear_slots();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 30;
    test_empty_pool();
    test_fill_and_preempt();
    test_release_and_lookup();
    test_random_traffic(0, 600);
    test_random_traffic(64, 550);
    test_random_traffic(9, 550);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SLOTS + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
